// ===== hw/rtl/lpwbd_pkg.sv =====
// Shared types and constants for the light pulse width bit decoder.
package lpwbd_pkg;

  localparam int unsigned TRAINING_PAIRS = 4;
  localparam int unsigned TRAIN_SHIFT = $clog2(TRAINING_PAIRS);
  localparam int unsigned PARITY_GROUP = 4;
  localparam int unsigned PARITY_BITS = $clog2(PARITY_GROUP);
  localparam int unsigned LEGACY_SHIFT = 2;

  typedef enum logic [2:0] {
    PH_HDR_MARK    = 3'd0,
    PH_HDR_SPACE   = 3'd1,
    PH_TRAIN_MARK  = 3'd2,
    PH_TRAIN_SPACE = 3'd3,
    PH_DATA_MARK   = 3'd4,
    PH_DATA_SPACE  = 3'd5,
    PH_PAR_MARK    = 3'd6,
    PH_PAR_SPACE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    CFG_LEGACY_MODE    = 3'd0,
    CFG_HDR_MIN        = 3'd1,
    CFG_HDR_MAX        = 3'd2,
    CFG_LEGACY_HDR_MIN = 3'd3,
    CFG_LEGACY_HDR_MAX = 3'd4
  } cfg_idx_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_PARITY_FAIL = 1'b1;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] mark_thr;
    logic [15:0] space_thr;
    logic [7:0]  pair_count;
    logic        parity;
  } rx_state_t;

  typedef struct packed {
    logic        legacy_mode;
    logic [15:0] hdr_min;
    logic [15:0] hdr_max;
    logic [15:0] legacy_hdr_min;
    logic [15:0] legacy_hdr_max;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic event_kind;
    logic bit_value;
  } rx_result_t;

endpackage

// ===== hw/rtl/lpwbd_step.sv =====
// Per-edge receive logic: next receive state and the optional result.
module lpwbd_step import lpwbd_pkg::*; (
  input  rx_state_t   state,
  input  cfg_t        cfg,
  input  logic [15:0] interval_us,
  input  logic        interval_too_long,
  input  logic        restart,
  output rx_state_t   state_nxt,
  output rx_result_t  result
);

  logic        norm_win;
  logic        leg_win;
  logic        mark_bit;
  logic        space_bit;
  logic [7:0]  pc_inc;
  logic [15:0] space_sum;
  logic [15:0] mark_sum;

  assign norm_win  = (interval_us >= cfg.hdr_min) && (interval_us <= cfg.hdr_max);
  assign leg_win   = (interval_us >= cfg.legacy_hdr_min) &&
                     (interval_us <= cfg.legacy_hdr_max);
  assign mark_bit  = interval_us > state.mark_thr;
  assign space_bit = interval_us > state.space_thr;
  assign pc_inc    = state.pair_count + 8'd1;
  assign space_sum = state.space_thr + interval_us;
  assign mark_sum  = state.mark_thr + interval_us;

  always_comb begin
    state_nxt = state;
    result    = '0;
    if (restart) begin
      state_nxt = '0;
      state_nxt.phase = PH_HDR_MARK;
    end else if (interval_too_long) begin
      state_nxt = state;
    end else if (cfg.legacy_mode) begin
      case (state.phase)
        PH_HDR_MARK: begin
          if (leg_win) state_nxt.phase = PH_HDR_SPACE;
        end
        PH_HDR_SPACE: begin
          if (leg_win) begin
            state_nxt.phase    = PH_DATA_MARK;
            state_nxt.mark_thr = interval_us >> LEGACY_SHIFT;
          end
        end
        PH_DATA_MARK: begin
          state_nxt.phase   = PH_DATA_SPACE;
          result.emit       = 1'b1;
          result.event_kind = KIND_DATA;
          result.bit_value  = mark_bit;
        end
        PH_DATA_SPACE: begin
          state_nxt.phase = PH_DATA_MARK;
        end
        default: begin
          state_nxt = state;
        end
      endcase
    end else begin
      case (state.phase)
        PH_HDR_MARK: begin
          if (norm_win) state_nxt.phase = PH_HDR_SPACE;
        end
        PH_HDR_SPACE: begin
          if (norm_win) state_nxt.phase = PH_TRAIN_MARK;
        end
        PH_TRAIN_MARK: begin
          state_nxt.mark_thr = mark_sum;
          state_nxt.phase    = PH_TRAIN_SPACE;
        end
        PH_TRAIN_SPACE: begin
          if (pc_inc < 8'(TRAINING_PAIRS)) begin
            state_nxt.pair_count = pc_inc;
            state_nxt.space_thr  = space_sum;
            state_nxt.phase      = PH_TRAIN_MARK;
          end else begin
            state_nxt.mark_thr   = state.mark_thr >> TRAIN_SHIFT;
            state_nxt.space_thr  = space_sum >> TRAIN_SHIFT;
            state_nxt.pair_count = '0;
            state_nxt.parity     = 1'b0;
            state_nxt.phase      = PH_DATA_MARK;
          end
        end
        PH_DATA_MARK: begin
          state_nxt.pair_count = pc_inc;
          state_nxt.parity     = state.parity ^ mark_bit;
          state_nxt.phase      = PH_DATA_SPACE;
          result.emit          = 1'b1;
          result.event_kind    = KIND_DATA;
          result.bit_value     = mark_bit;
        end
        PH_DATA_SPACE: begin
          state_nxt.parity  = state.parity ^ space_bit;
          state_nxt.phase   = (state.pair_count[PARITY_BITS-1:0] == '0) ?
                              PH_PAR_MARK : PH_DATA_MARK;
          result.emit       = 1'b1;
          result.event_kind = KIND_DATA;
          result.bit_value  = space_bit;
        end
        PH_PAR_MARK: begin
          if (state.parity != mark_bit) begin
            state_nxt         = '0;
            state_nxt.phase   = PH_HDR_MARK;
            result.emit       = 1'b1;
            result.event_kind = KIND_PARITY_FAIL;
            result.bit_value  = 1'b0;
          end else begin
            state_nxt.phase = PH_PAR_SPACE;
          end
        end
        default: begin
          state_nxt.phase = PH_DATA_MARK;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/light_pulse_width_bit_decoder_unit.sv =====
// Top level of the light pulse width bit decoder: registers, handshakes, config.
// A result is registered on the output register when its edge is accepted.
// Throughput: one edge per cycle while in_stall is low; the receive state updates in the accepting cycle.
// A held result only stalls the input while the output side is stalling it.
// Reset (rst_n low, synchronous) clears the receive state and output valid and
// loads the config registers with 0, 1000, 3000, 1000, 3000.
module light_pulse_width_bit_decoder_unit import lpwbd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_interval_us,
  input  logic        in_interval_too_long,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic        out_bit_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rx_state_t  state_r;
  rx_state_t  state_nxt;
  cfg_t       cfg_r;
  rx_result_t result;
  logic       out_valid_r;
  logic       event_kind_r;
  logic       bit_value_r;
  logic       in_fire;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lpwbd_step u_step (
    .state             (state_r),
    .cfg               (cfg_r),
    .interval_us       (in_interval_us),
    .interval_too_long (in_interval_too_long),
    .restart           (in_restart),
    .state_nxt         (state_nxt),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_HDR_MARK, default: '0};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.legacy_mode    <= 1'b0;
      cfg_r.hdr_min        <= 16'd1000;
      cfg_r.hdr_max        <= 16'd3000;
      cfg_r.legacy_hdr_min <= 16'd1000;
      cfg_r.legacy_hdr_max <= 16'd3000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEGACY_MODE:    cfg_r.legacy_mode    <= cfg_data[0];
        CFG_HDR_MIN:        cfg_r.hdr_min        <= cfg_data;
        CFG_HDR_MAX:        cfg_r.hdr_max        <= cfg_data;
        CFG_LEGACY_HDR_MIN: cfg_r.legacy_hdr_min <= cfg_data;
        CFG_LEGACY_HDR_MAX: cfg_r.legacy_hdr_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= result.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && result.emit) begin
      event_kind_r <= result.event_kind;
      bit_value_r  <= result.bit_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = event_kind_r;
  assign out_bit_value  = bit_value_r;

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_restart |=> state_r.phase == PH_HDR_MARK && state_r.pair_count == '0)
    else $error("restart did not clear the receive state");

  a_fail_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && event_kind_r == KIND_PARITY_FAIL |-> !bit_value_r)
    else $error("parity failure transaction carries a nonzero bit");

  a_train_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_TRAIN_MARK || state_r.phase == PH_TRAIN_SPACE |->
      state_r.pair_count < 8'(TRAINING_PAIRS))
    else $error("training pair count out of range");

  a_no_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && !(out_valid_r && out_stall) |=> !out_valid_r)
    else $error("result appeared without an accepted edge");
`endif

endmodule

// ===== dv/light_pulse_width_bit_decoder_unit_test.sv =====
// Self-checking testbench for the light pulse width bit decoder unit.
module light_pulse_width_bit_decoder_unit_test;
  import lpwbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct {
    logic kind;
    logic bit_value;
  } decoded_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_interval_us = '0;
  logic        in_interval_too_long = 1'b0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_event_kind;
  logic        out_bit_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  phase_t      rx_phase;
  logic [15:0] rx_mark_thr;
  logic [15:0] rx_space_thr;
  logic [7:0]  rx_pairs;
  logic        rx_parity;
  cfg_t        rx_cfg;

  decoded_event_t pending_events[$];
  decoded_event_t head;
  int unsigned    error_count = 0;
  int unsigned    quiet_cycles = 0;
  bit             idle_enable = 1'b1;
  bit             hold_request = 1'b0;

  light_pulse_width_bit_decoder_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_interval_us       (in_interval_us),
    .in_interval_too_long (in_interval_too_long),
    .in_restart           (in_restart),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_event_kind       (out_event_kind),
    .out_bit_value        (out_bit_value),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic clear_rx();
    rx_phase = PH_HDR_MARK;
    rx_mark_thr = '0;
    rx_space_thr = '0;
    rx_pairs = '0;
    rx_parity = 1'b0;
  endtask

  task automatic decode_edge(input logic [15:0] iv, input logic tl, input logic rs);
    logic b;
    logic in_win;
    if (rs) begin
      clear_rx();
      return;
    end
    if (tl) return;
    if (rx_cfg.legacy_mode) begin
      in_win = (iv >= rx_cfg.legacy_hdr_min) && (iv <= rx_cfg.legacy_hdr_max);
      case (rx_phase)
        PH_HDR_MARK: if (in_win) rx_phase = PH_HDR_SPACE;
        PH_HDR_SPACE: begin
          if (in_win) begin
            rx_phase = PH_DATA_MARK;
            rx_mark_thr = iv >> LEGACY_SHIFT;
          end
        end
        PH_DATA_MARK: begin
          rx_phase = PH_DATA_SPACE;
          pending_events.push_back('{KIND_DATA, iv > rx_mark_thr});
        end
        PH_DATA_SPACE: rx_phase = PH_DATA_MARK;
        default: ;
      endcase
      return;
    end
    in_win = (iv >= rx_cfg.hdr_min) && (iv <= rx_cfg.hdr_max);
    case (rx_phase)
      PH_HDR_MARK: if (in_win) rx_phase = PH_HDR_SPACE;
      PH_HDR_SPACE: if (in_win) rx_phase = PH_TRAIN_MARK;
      PH_TRAIN_MARK: begin
        rx_mark_thr = rx_mark_thr + iv;
        rx_phase = PH_TRAIN_SPACE;
      end
      PH_TRAIN_SPACE: begin
        rx_pairs = rx_pairs + 8'd1;
        rx_space_thr = rx_space_thr + iv;
        if (rx_pairs < TRAINING_PAIRS) begin
          rx_phase = PH_TRAIN_MARK;
        end else begin
          rx_mark_thr = rx_mark_thr >> TRAIN_SHIFT;
          rx_space_thr = rx_space_thr >> TRAIN_SHIFT;
          rx_pairs = '0;
          rx_parity = 1'b0;
          rx_phase = PH_DATA_MARK;
        end
      end
      PH_DATA_MARK: begin
        rx_pairs = rx_pairs + 8'd1;
        b = iv > rx_mark_thr;
        rx_parity = rx_parity ^ b;
        rx_phase = PH_DATA_SPACE;
        pending_events.push_back('{KIND_DATA, b});
      end
      PH_DATA_SPACE: begin
        b = iv > rx_space_thr;
        rx_parity = rx_parity ^ b;
        rx_phase = ((rx_pairs % PARITY_GROUP) == 0) ? PH_PAR_MARK : PH_DATA_MARK;
        pending_events.push_back('{KIND_DATA, b});
      end
      PH_PAR_MARK: begin
        b = iv > rx_mark_thr;
        if (rx_parity != b) begin
          clear_rx();
          pending_events.push_back('{KIND_PARITY_FAIL, 1'b0});
        end else begin
          rx_phase = PH_PAR_SPACE;
        end
      end
      default: rx_phase = PH_DATA_MARK;
    endcase
  endtask

  // Caller is at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_edge(input logic [15:0] iv, input logic tl, input logic rs);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_interval_us <= iv;
    in_interval_too_long <= tl;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    decode_edge(iv, tl, rs);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEGACY_MODE:    rx_cfg.legacy_mode = val[0];
      CFG_HDR_MIN:        rx_cfg.hdr_min = val;
      CFG_HDR_MAX:        rx_cfg.hdr_max = val;
      CFG_LEGACY_HDR_MIN: rx_cfg.legacy_hdr_min = val;
      CFG_LEGACY_HDR_MAX: rx_cfg.legacy_hdr_max = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic pick_window(input int unsigned kind, output logic [15:0] lo,
                             output logic [15:0] hi);
    int unsigned a;
    case (kind)
      0: begin
        lo = 16'd1000;
        hi = 16'd3000;
      end
      1: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      2: begin
        a = $urandom_range(65535, 1);
        lo = 16'(a);
        hi = 16'($urandom_range(a - 1, 0));
      end
      3: begin
        lo = 16'($urandom_range(4000, 0));
        hi = lo;
      end
      default: begin
        lo = 16'($urandom_range(2000, 0));
        hi = lo + 16'($urandom_range(4000, 0));
      end
    endcase
  endtask

  task automatic configure_decoder(input int unsigned sel);
    logic        mode;
    logic [15:0] lo, hi, llo, lhi;
    int unsigned kind, lkind;
    mode = 1'($urandom_range(0, 1));
    kind = $urandom_range(0, 9);
    lkind = $urandom_range(0, 9);
    case (sel)
      0: begin
        mode = 1'b0;
        kind = 1;
        lkind = 1;
      end
      1: begin
        mode = 1'b1;
        kind = 0;
        lkind = 0;
      end
      2: begin
        kind = 2;
        lkind = 2;
      end
      default: ;
    endcase
    pick_window(kind, lo, hi);
    pick_window(lkind, llo, lhi);
    write_reg(CFG_HDR_MIN, lo);
    write_reg(CFG_HDR_MAX, hi);
    write_reg(CFG_LEGACY_HDR_MIN, llo);
    write_reg(CFG_LEGACY_HDR_MAX, lhi);
    write_reg(CFG_LEGACY_MODE, {15'd0, mode});
  endtask

  // Mostly well-formed edges for the current receive phase, some noise.
  task automatic pick_edge(output logic [15:0] iv, output logic tl, output logic rs);
    int unsigned r, thr, lo, hi;
    logic want;
    r = $urandom_range(0, 99);
    tl = 1'b0;
    rs = 1'b0;
    iv = 16'($urandom());
    if (r < 3) begin
      rs = 1'b1;
      tl = 1'($urandom_range(0, 1));
      return;
    end
    if (r < 11) begin
      tl = 1'b1;
      return;
    end
    if (r < 15) return;
    lo = 32'(rx_cfg.legacy_mode ? rx_cfg.legacy_hdr_min : rx_cfg.hdr_min);
    hi = 32'(rx_cfg.legacy_mode ? rx_cfg.legacy_hdr_max : rx_cfg.hdr_max);
    thr = 32'((rx_phase == PH_DATA_SPACE && !rx_cfg.legacy_mode) ?
              rx_space_thr : rx_mark_thr);
    case (rx_phase)
      PH_HDR_MARK, PH_HDR_SPACE: begin
        if (lo <= hi) begin
          case ($urandom_range(0, 3))
            0: iv = 16'(lo);
            1: iv = 16'(hi);
            default: iv = 16'($urandom_range(hi, lo));
          endcase
        end
      end
      PH_TRAIN_MARK, PH_TRAIN_SPACE: begin
        if ($urandom_range(0, 3) != 0) iv = 16'($urandom_range(1500, 100));
      end
      PH_DATA_MARK, PH_DATA_SPACE: begin
        case ($urandom_range(0, 5))
          0: iv = 16'(thr);
          1: iv = 16'(thr + 1);
          2: iv = 16'(thr - 1);
          3: ;
          default: iv = 16'($urandom_range(0, (thr * 2 > 65535) ? 65535 : thr * 2));
        endcase
      end
      PH_PAR_MARK: begin
        want = rx_parity ^ ($urandom_range(0, 3) == 0);
        if (!want) iv = 16'($urandom_range(thr, 0));
        else if (thr == 65535) iv = 16'hFFFF;
        else iv = 16'($urandom_range(thr + 1,
                                     (thr * 2 + 1 > 65535) ? 65535 : thr * 2 + 1));
      end
      default: ;
    endcase
  endtask

  task automatic test_normal_frame();
    send_edge(16'd999, 1'b0, 1'b0);
    send_edge(16'd1000, 1'b0, 1'b0);
    send_edge(16'd3000, 1'b0, 1'b0);
    // training: mark sum wraps past 16 bits
    send_edge(16'hFFFF, 1'b0, 1'b0);
    send_edge(16'd300, 1'b0, 1'b0);
    send_edge(16'd600, 1'b0, 1'b0);
    send_edge(16'd300, 1'b0, 1'b0);
    send_edge(16'd600, 1'b0, 1'b0);
    send_edge(16'd300, 1'b0, 1'b0);
    send_edge(16'd600, 1'b0, 1'b0);
    send_edge(16'd300, 1'b0, 1'b0);
    send_edge(16'd449, 1'b0, 1'b0);
    send_edge(16'd300, 1'b0, 1'b0);
    send_edge(16'd450, 1'b0, 1'b0);
    send_edge(16'd301, 1'b0, 1'b0);
    send_edge(16'd0, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b0);
    send_edge(16'd0, 1'b0, 1'b0);
    // parity mark disagrees
    send_edge(16'd450, 1'b0, 1'b0);
  endtask

  task automatic test_ignored_edges();
    send_edge(16'd1000, 1'b1, 1'b0);
    send_edge(16'd1000, 1'b0, 1'b0);
    send_edge(16'd2000, 1'b1, 1'b1);
    send_edge(16'd1500, 1'b0, 1'b0);
    send_edge(16'hFFFF, 1'b0, 1'b1);
  endtask

  task automatic test_mode_switch();
    send_edge(16'd1000, 1'b0, 1'b0);
    send_edge(16'd1000, 1'b0, 1'b0);
    send_edge(16'd500, 1'b0, 1'b0);
    drain_results();
    write_reg(CFG_LEGACY_MODE, 16'd1);
    send_edge(16'd500, 1'b0, 1'b0);
    drain_results();
    write_reg(CFG_LEGACY_MODE, 16'd0);
    send_edge(16'd500, 1'b0, 1'b0);
  endtask

  task automatic test_output_backpressure();
    int unsigned guard;
    logic [15:0] iv;
    logic tl, rs;
    guard = 0;
    while (rx_phase != PH_DATA_MARK && guard < 80) begin
      pick_edge(iv, tl, rs);
      send_edge(iv, tl, rs);
      guard++;
    end
    idle_enable = 1'b0;
    hold_request = 1'b1;
    repeat (16) begin
      pick_edge(iv, tl, rs);
      send_edge(iv, tl, rs);
    end
    drain_results();
    idle_enable = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned counted, n, phase_len, sel;
    logic [15:0] iv;
    logic tl, rs;
    counted = 0;
    sel = 0;
    while (counted < 300) begin
      drain_results();
      configure_decoder(sel);
      sel++;
      idle_enable = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 90);
      n = 0;
      while (n < phase_len) begin
        pick_edge(iv, tl, rs);
        send_edge(iv, tl, rs);
        if (!tl && !rs) n++;
      end
      counted += n;
    end
  endtask

  task automatic test_final_stretch();
    int unsigned n;
    logic [15:0] iv;
    logic tl, rs;
    idle_enable = 1'b0;
    n = 0;
    while (n < 50) begin
      pick_edge(iv, tl, rs);
      send_edge(iv, tl, rs);
      if (!tl && !rs) n++;
    end
  endtask

  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        head = pending_events.pop_front();
        if (out_event_kind !== head.kind)
          report_mismatch($sformatf("event_kind %b, expected %b", out_event_kind, head.kind));
        if (out_bit_value !== head.bit_value)
          report_mismatch($sformatf("bit_value %b, expected %b", out_bit_value, head.bit_value));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_cfg = '{legacy_mode: 1'b0, hdr_min: 16'd1000, hdr_max: 16'd3000,
               legacy_hdr_min: 16'd1000, legacy_hdr_max: 16'd3000};
    clear_rx();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_normal_frame();
    test_ignored_edges();
    test_mode_switch();
    test_output_backpressure();
    test_random_streams();
    test_final_stretch();
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lpwbd_pkg.sv
hw/rtl/lpwbd_step.sv
hw/rtl/light_pulse_width_bit_decoder_unit.sv
dv/light_pulse_width_bit_decoder_unit_test.sv
